>>> src/akld_pkg.sv
// ----------------------------------------------------------------------------
// akld_pkg
// Shared types and constants for the ladder keypad debouncer: key bits,
// ladder thresholds, configuration register indexes and reset values.
// ----------------------------------------------------------------------------
package akld_pkg;

    // Key bit positions in the key mask.
    localparam int unsigned KEY_W = 6;
    localparam logic [KEY_W-1:0] KEY_NONE = 6'h00;
    localparam logic [KEY_W-1:0] KEY_LR   = 6'h01;
    localparam logic [KEY_W-1:0] KEY_FA   = 6'h02;
    localparam logic [KEY_W-1:0] KEY_UV   = 6'h04;
    localparam logic [KEY_W-1:0] KEY_MENU = 6'h08;
    localparam logic [KEY_W-1:0] KEY_VOL  = 6'h10;
    localparam logic [KEY_W-1:0] KEY_PTT  = 6'h20;

    // Field widths.
    localparam int unsigned SAMPLE_W = 8;
    localparam int unsigned OFFSET_W = 6;
    localparam int unsigned LIMIT_W  = 8;
    localparam int unsigned CFG_W    = 8;
    // Sample plus offset needs one extra bit.
    localparam int unsigned SUM_W    = SAMPLE_W + 1;

    // Ladder thresholds, compared against sample plus offset.
    localparam logic [SUM_W-1:0] THR_NONE = 9'd255;
    localparam logic [SUM_W-1:0] THR_LR   = 9'd207;
    localparam logic [SUM_W-1:0] THR_FA   = 9'd155;
    localparam logic [SUM_W-1:0] THR_UV   = 9'd100;
    localparam logic [SUM_W-1:0] THR_MENU = 9'd50;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_ADC_OFFSET     = 1'b0,
        CFG_DEBOUNCE_LIMIT = 1'b1
    } t_cfg_idx;

    // Reset values of the configuration registers.
    localparam logic [OFFSET_W-1:0] OFFSET_RST = 6'd10;
    localparam logic [LIMIT_W-1:0]  LIMIT_RST  = 8'd50;

    // Configuration as seen by the datapath.
    typedef struct packed {
        logic [OFFSET_W-1:0] adc_offset;
        logic [LIMIT_W-1:0]  debounce_limit;
    } t_cfg;

endpackage

>>> src/akld_classify.sv
// ----------------------------------------------------------------------------
// akld_classify
// Maps one ladder sample and the PTT level to a raw key pattern.
// ----------------------------------------------------------------------------
module akld_classify (
    input  logic [akld_pkg::SAMPLE_W-1:0] i_ladder_sample,
    input  logic                          i_ptt_line,
    input  logic [akld_pkg::OFFSET_W-1:0] i_adc_offset,
    output logic [akld_pkg::KEY_W-1:0]    o_keys
);

    logic [akld_pkg::SUM_W-1:0] sum;
    logic [akld_pkg::KEY_W-1:0] band;

    // Comparing sample + offset against the fixed threshold is the same as
    // comparing the sample against the threshold less the offset, and it
    // stays unsigned even when the lowered threshold would go negative.
    assign sum = {1'b0, i_ladder_sample}
               + {{(akld_pkg::SUM_W-akld_pkg::OFFSET_W){1'b0}}, i_adc_offset};

    // Pick the band from the top down.
    always_comb begin
        priority if (sum > akld_pkg::THR_NONE) begin
            band = akld_pkg::KEY_NONE;
        end else if (sum > akld_pkg::THR_LR) begin
            band = akld_pkg::KEY_LR;
        end else if (sum > akld_pkg::THR_FA) begin
            band = akld_pkg::KEY_FA;
        end else if (sum > akld_pkg::THR_UV) begin
            band = akld_pkg::KEY_UV;
        end else if (sum > akld_pkg::THR_MENU) begin
            band = akld_pkg::KEY_MENU;
        end else begin
            band = akld_pkg::KEY_VOL;
        end
    end

    // PTT is active low.
    assign o_keys = i_ptt_line ? band : (band | akld_pkg::KEY_PTT);

endmodule

>>> src/akld_integrator.sv
// ----------------------------------------------------------------------------
// akld_integrator
// Integrator debounce: holds the count and the last accepted keys, and
// produces the result for each request that steps through.
// ----------------------------------------------------------------------------
module akld_integrator (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_step,
    input  logic [akld_pkg::KEY_W-1:0]   i_keys,
    input  logic [akld_pkg::LIMIT_W-1:0] i_limit,
    output logic [akld_pkg::KEY_W-1:0]   o_result
);

    logic [akld_pkg::LIMIT_W-1:0] r_count;
    logic [akld_pkg::LIMIT_W-1:0] n_count;
    logic [akld_pkg::KEY_W-1:0]   r_accepted;
    logic [akld_pkg::KEY_W-1:0]   n_accepted;
    logic [akld_pkg::LIMIT_W-1:0] count_mid;
    logic                         accept;

    // Count down while the pattern matches, up toward the limit otherwise.
    always_comb begin
        if (i_keys == r_accepted) begin
            count_mid = (r_count != '0) ? r_count - 1'b1 : r_count;
        end else begin
            count_mid = (r_count < i_limit) ? r_count + 1'b1 : r_count;
        end
    end

    // Accept when a nonzero count has reached the limit.
    assign accept     = (count_mid != '0) && (count_mid >= i_limit);
    assign n_count    = accept ? i_limit : count_mid;
    assign n_accepted = accept ? i_keys : r_accepted;
    assign o_result   = accept ? i_keys : akld_pkg::KEY_NONE;

    // State moves only when a request passes to the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_accepted <= akld_pkg::KEY_NONE;
        end else if (i_step) begin
            r_count    <= n_count;
            r_accepted <= n_accepted;
        end
    end

endmodule

>>> src/adc_key_ladder_debouncer.sv
// A request accepted into the input register moves on to the result register
// once that register is free. Throughput: one request per cycle while the key
// channel is not stalled; the input register, the classify and integrator
// logic and the result register form a two-stage pipeline.
// The integrator state updates as a request moves into the result register.
// Reset (synchronous, active low) empties both stages, clears the integrator
// and accepted keys, and loads adc_offset 10 and debounce_limit 50.
// ----------------------------------------------------------------------------
// adc_key_ladder_debouncer
// Resistor ladder keypad decoder with integrator debounce, top level.
// ----------------------------------------------------------------------------
module adc_key_ladder_debouncer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration write port.
    input  logic                          i_cfg_we,
    input  logic [0:0]                    i_cfg_index,
    input  logic [akld_pkg::CFG_W-1:0]    i_cfg_data,
    // Sample channel.
    input  logic                          i_sample_valid,
    output logic                          o_sample_ready,
    input  logic [akld_pkg::SAMPLE_W-1:0] i_ladder_sample,
    input  logic                          i_ptt_line,
    // Key channel.
    output logic                          o_key_valid,
    input  logic                          i_key_ready,
    output logic [akld_pkg::KEY_W-1:0]    o_key_mask
);

    akld_pkg::t_cfg                r_cfg;
    logic                          r_in_valid;
    logic [akld_pkg::SAMPLE_W-1:0] r_sample;
    logic                          r_ptt;
    logic                          r_out_valid;
    logic [akld_pkg::KEY_W-1:0]    r_key_mask;
    logic                          out_free;
    logic                          step;
    logic [akld_pkg::KEY_W-1:0]    keys;
    logic [akld_pkg::KEY_W-1:0]    result;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.adc_offset     <= akld_pkg::OFFSET_RST;
            r_cfg.debounce_limit <= akld_pkg::LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (akld_pkg::t_cfg_idx'(i_cfg_index))
                akld_pkg::CFG_ADC_OFFSET: begin
                    r_cfg.adc_offset <= i_cfg_data[akld_pkg::OFFSET_W-1:0];
                end
                akld_pkg::CFG_DEBOUNCE_LIMIT: begin
                    r_cfg.debounce_limit <= i_cfg_data[akld_pkg::LIMIT_W-1:0];
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    // Pipeline handshake: the result register frees when it is taken.
    assign out_free       = !r_out_valid || i_key_ready;
    assign step           = r_in_valid && out_free;
    assign o_sample_ready = !r_in_valid || out_free;

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_sample_ready) begin
                r_in_valid <= i_sample_valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // Input register payload.
    always_ff @(posedge i_clk) begin
        if (i_sample_valid && o_sample_ready) begin
            r_sample <= i_ladder_sample;
            r_ptt    <= i_ptt_line;
        end
    end

    akld_classify u_classify (
        .i_ladder_sample (r_sample),
        .i_ptt_line      (r_ptt),
        .i_adc_offset    (r_cfg.adc_offset),
        .o_keys          (keys)
    );

    akld_integrator u_integrator (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_keys   (keys),
        .i_limit  (r_cfg.debounce_limit),
        .o_result (result)
    );

    // Result register payload.
    always_ff @(posedge i_clk) begin
        if (step) begin
            r_key_mask <= result;
        end
    end

    assign o_key_valid = r_out_valid;
    assign o_key_mask  = r_key_mask;

endmodule

>>> src/akld_checker.sv
// ----------------------------------------------------------------------------
// akld_checker
// Port-level checks for the ladder keypad debouncer, bound to the top level.
// ----------------------------------------------------------------------------
module akld_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_sample_ready,
    input logic                          o_key_valid,
    input logic                          i_key_ready,
    input logic [akld_pkg::KEY_W-1:0]    o_key_mask
);

    // A stalled result holds its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_key_valid && !i_key_ready |=> o_key_valid && $stable(o_key_mask))
        else $error("key result changed while stalled");

    // Reset leaves no result pending.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_key_valid)
        else $error("key result valid after reset");

    // Requests are refused only when the output side is stalled.
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_sample_ready |-> o_key_valid && !i_key_ready)
        else $error("sample refused without output backpressure");

    // At most one ladder key appears in a result.
    a_onekey: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_key_valid |-> $onehot0(o_key_mask[4:0]))
        else $error("more than one ladder key in result");

endmodule

bind adc_key_ladder_debouncer akld_checker u_akld_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_sample_ready (o_sample_ready),
    .o_key_valid    (o_key_valid),
    .i_key_ready    (i_key_ready),
    .o_key_mask     (o_key_mask)
);
